// ===== sv/mm3bft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3bft_pkg
// Shared types, register indexes, reset values and saturating helpers for
// the bond stretch force and tally block.
// ----------------------------------------------------------------------------
package mm3bft_pkg;

   // register indexes on the csr channel
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_CUBIC   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUARTIC = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEWTON  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VIRIAL  = 8'd4;

   // register reset values
   localparam logic signed [31:0] CUBIC_RESET   = -32'sd167117;
   localparam logic signed [31:0] QUARTIC_RESET = 32'sd248586;

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
   localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

   typedef struct packed {
      logic signed [31:0] cubic_coeff;
      logic signed [31:0] quartic_coeff;
      logic               newton_mode;
      logic               energy_enable;
      logic               virial_enable;
   } cfg_type;

   // one bond as held in the queue, with its local end count
   typedef struct packed {
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic [31:0]        rest_length;
      logic [31:0]        stiffness;
      logic               start_of_pass;
      logic [1:0]         local_ends;
   } item_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] bond_energy;
      logic signed [63:0] energy_total;
      logic signed [63:0] virial_xx;
      logic signed [63:0] virial_yy;
      logic signed [63:0] virial_zz;
      logic signed [63:0] virial_xy;
      logic signed [63:0] virial_xz;
      logic signed [63:0] virial_yz;
   } result_type;

   // magnitude of a signed word
   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   // saturating signed add
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   // clamp to the 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
      if (a > 64'(S32_MAX)) return S32_MAX;
      if (a < 64'(S32_MIN)) return S32_MIN;
      return a[31:0];
   endfunction

   // half, rounded toward zero
   function automatic logic signed [63:0] half64(input logic signed [63:0] a);
      logic signed [63:0] b;
      b = a + {63'd0, a[63]};
      return b >>> 1;
   endfunction

endpackage

// ===== sv/mm3bft_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3bft channel interfaces
// Bond request, result and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface mm3bft_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] delta_x;
   logic signed [31:0] delta_y;
   logic signed [31:0] delta_z;
   logic [31:0]        rest_length;
   logic [31:0]        stiffness;
   logic               first_local;
   logic               second_local;
   logic               start_of_pass;

   modport source (output valid, delta_x, delta_y, delta_z, rest_length, stiffness,
                   first_local, second_local, start_of_pass, input ready);
   modport sink (input valid, delta_x, delta_y, delta_z, rest_length, stiffness,
                 first_local, second_local, start_of_pass, output ready);
endinterface

interface mm3bft_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic signed [31:0] force_z;
   logic signed [31:0] bond_energy;
   logic signed [63:0] energy_total;
   logic signed [63:0] virial_xx;
   logic signed [63:0] virial_yy;
   logic signed [63:0] virial_zz;
   logic signed [63:0] virial_xy;
   logic signed [63:0] virial_xz;
   logic signed [63:0] virial_yz;

   modport source (output valid, force_x, force_y, force_z, bond_energy, energy_total,
                   virial_xx, virial_yy, virial_zz, virial_xy, virial_xz, virial_yz,
                   input ready);
   modport sink (input valid, force_x, force_y, force_z, bond_energy, energy_total,
                 virial_xx, virial_yy, virial_zz, virial_xy, virial_xz, virial_yz,
                 output ready);
endinterface

interface mm3bft_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mm3bft_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3bft_front
// Accepts bonds, counts their local ends and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mm3bft_front
   import mm3bft_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mm3bft_req_if.sink   req_ch,
   output logic         q_valid,
   output item_type     q_item,
   input  logic         q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   item_type   item_in;

   // classify the incoming item
   always_comb begin
      item_in.delta_x       = req_ch.delta_x;
      item_in.delta_y       = req_ch.delta_y;
      item_in.delta_z       = req_ch.delta_z;
      item_in.rest_length   = req_ch.rest_length;
      item_in.stiffness     = req_ch.stiffness;
      item_in.start_of_pass = req_ch.start_of_pass;
      item_in.local_ends    = {1'b0, req_ch.first_local} + {1'b0, req_ch.second_local};
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != 2'd0);
   assign q_item       = slot_ff[rd_ptr_ff];

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= item_in;
   end

endmodule

// ===== sv/mm3bft_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3bft_mul
// Fixed point multiply of two signed 64-bit words from four 32x32 partial
// products, truncated toward zero and saturated; raw mode gives the low word.
// ----------------------------------------------------------------------------
module mm3bft_mul
   import mm3bft_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               raw,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   output logic               done,
   output logic signed [63:0] res
);

   logic [63:0]        ua_ff, ub_ff;
   logic               neg_ff, raw_ff;
   logic [127:0]       acc_ff, acc_in, pp_sh;
   logic [1:0]         step_ff;
   logic               busy_ff, fin_ff, done_ff;
   logic signed [63:0] res_ff, fin_val;
   logic [31:0]        sa, sb;
   logic [63:0]        pp, lo;
   logic [63-FRACTION_BITS:0] hi;

   // one partial product per cycle
   always_comb begin
      sa = step_ff[0] ? ua_ff[63:32] : ua_ff[31:0];
      sb = step_ff[1] ? ub_ff[63:32] : ub_ff[31:0];
      pp = {32'd0, sa} * {32'd0, sb};
      case (step_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
      acc_in = acc_ff + pp_sh;
   end

   // shift, truncate and saturate
   always_comb begin
      hi = acc_ff[127:64+FRACTION_BITS];
      lo = acc_ff[63+FRACTION_BITS:FRACTION_BITS];
      if (raw_ff) fin_val = acc_ff[63:0];
      else if (hi != '0) fin_val = neg_ff ? S64_MIN : S64_MAX;
      else if (neg_ff) fin_val = lo[63] ? S64_MIN : 64'(-lo);
      else fin_val = lo[63] ? S64_MAX : 64'(lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= mag64(op_a);
         ub_ff  <= mag64(op_b);
         neg_ff <= op_a[63] ^ op_b[63];
         raw_ff <= raw;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
      if (fin_ff) res_ff <= fin_val;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ===== sv/mm3bft_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3bft_root
// Integer square root of a 64-bit word, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module mm3bft_root (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [32:0] root
);

   logic [63:0] v_ff, res_ff, bit_ff;
   logic [63:0] trial;
   logic        ge, busy_ff, done_ff;

   assign trial = res_ff + bit_ff;
   assign ge    = (v_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == 64'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // one restoring step per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (busy_ff) begin
         v_ff   <= ge ? v_ff - trial : v_ff;
         res_ff <= ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[32:0];

endmodule

// ===== sv/mm3bft_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3bft_div
// Fixed point divide of a signed word by a positive length, one quotient
// bit per cycle, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module mm3bft_div
   import mm3bft_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [32:0]        divisor,
   output logic               done,
   output logic signed [63:0] quotient
);

   localparam int W  = 64 + FRACTION_BITS;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]       num_ff, quo_ff;
   logic [33:0]        rem_ff, rem_sh;
   logic [32:0]        den_ff;
   logic               neg_ff, ge;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff, fin_ff, done_ff;
   logic signed [63:0] quo_out_ff, fin_val;

   assign rem_sh = {rem_ff[32:0], num_ff[W-1]};
   assign ge     = (rem_sh >= {1'b0, den_ff});

   // overflow when the quotient reaches the sign bit
   always_comb begin
      if (quo_ff[W-1:63] != '0) fin_val = neg_ff ? S64_MIN : S64_MAX;
      else if (neg_ff) fin_val = 64'(-quo_ff[63:0]);
      else fin_val = quo_ff[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {mag64(dividend), {FRACTION_BITS{1'b0}}};
         den_ff <= divisor;
         neg_ff <= dividend[63];
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff <= {quo_ff[W-2:0], ge};
      end
      if (fin_ff) quo_out_ff <= fin_val;
   end

   assign done     = done_ff;
   assign quotient = quo_out_ff;

endmodule

// ===== sv/mm3bft_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3bft_back
// Sequencer that works one bond through the shared multiplier, the square
// root and, for a nonzero length, the divider, then updates tallies and loads the result.
// ----------------------------------------------------------------------------
module mm3bft_back
   import mm3bft_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_valid,
   input  item_type      q_item,
   output logic          q_pop,
   mm3bft_rsp_if.source  rsp_ch
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MUL_GO    = 4'd1;
   localparam logic [3:0] ST_MUL_WAIT  = 4'd2;
   localparam logic [3:0] ST_ROOT_GO   = 4'd3;
   localparam logic [3:0] ST_ROOT_WAIT = 4'd4;
   localparam logic [3:0] ST_DIV_GO    = 4'd5;
   localparam logic [3:0] ST_DIV_WAIT  = 4'd6;
   localparam logic [3:0] ST_ACC       = 4'd7;
   localparam logic [3:0] ST_OUT       = 4'd8;

   // multiply steps
   localparam logic [4:0] PC_SQ_X   = 5'd0;
   localparam logic [4:0] PC_SQ_Y   = 5'd1;
   localparam logic [4:0] PC_SQ_Z   = 5'd2;
   localparam logic [4:0] PC_DR2    = 5'd3;
   localparam logic [4:0] PC_C3K    = 5'd4;
   localparam logic [4:0] PC_C3DR   = 5'd5;
   localparam logic [4:0] PC_C4K    = 5'd6;
   localparam logic [4:0] PC_C4DR2  = 5'd7;
   localparam logic [4:0] PC_K2DR   = 5'd8;
   localparam logic [4:0] PC_DE     = 5'd9;
   localparam logic [4:0] PC_E3     = 5'd10;
   localparam logic [4:0] PC_E4     = 5'd11;
   localparam logic [4:0] PC_EK2    = 5'd12;
   localparam logic [4:0] PC_EB     = 5'd13;
   localparam logic [4:0] PC_FX     = 5'd14;
   localparam logic [4:0] PC_FY     = 5'd15;
   localparam logic [4:0] PC_FZ     = 5'd16;
   localparam logic [4:0] PC_VIR    = 5'd17;
   localparam logic [4:0] PC_LAST   = 5'd28;

   localparam logic signed [63:0] C_ONE  = 64'sd1 <<< FRACTION_BITS;
   localparam logic signed [63:0] C_1P5  = 64'sd3 <<< (FRACTION_BITS - 1);
   localparam logic signed [63:0] C_TWO  = 64'sd2 <<< FRACTION_BITS;

   logic [3:0]         state_ff;
   logic [4:0]         pc_ff, vm;
   logic [2:0]         vidx;
   logic               acc_step_ff;
   logic signed [63:0] dx, dy, dz;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;
   logic [31:0]        r0_ff, k2_ff;
   logic               sop_ff;
   logic [1:0]         ends_ff;
   logic [63:0]        rsq_ff;
   logic [32:0]        r_ff;
   logic signed [63:0] dr_ff, dr2_ff, t_ff, poly_ff, pe_ff, de_ff, fb_ff;
   logic signed [31:0] eb_ff;
   logic signed [31:0] fc_ff [3];
   logic signed [63:0] vir_ff [6];
   logic signed [63:0] esum_ff;
   logic signed [63:0] vsum_ff [6];
   logic signed [63:0] esum_in;
   logic signed [63:0] vsum_in [6];
   logic signed [63:0] op_a, op_b;
   logic               op_raw;
   logic               mul_done, root_done, div_done;
   logic signed [63:0] mul_res, div_res;
   logic [32:0]        root_res;
   logic [1:0]         ia, ib;
   logic               add0, add1;
   logic signed [63:0] ebx;
   result_type         out_ff;
   logic               out_valid_ff, out_free;

   mm3bft_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock (clock), .reset (reset), .start (state_ff == ST_MUL_GO),
      .raw (op_raw), .op_a (op_a), .op_b (op_b), .done (mul_done), .res (mul_res)
   );

   mm3bft_root u_root (
      .clock (clock), .reset (reset), .start (state_ff == ST_ROOT_GO),
      .radicand (rsq_ff), .done (root_done), .root (root_res)
   );

   mm3bft_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock), .reset (reset), .start (state_ff == ST_DIV_GO),
      .dividend (de_ff), .divisor (r_ff), .done (div_done), .quotient (div_res)
   );

   assign dx = 64'(dx_ff);
   assign dy = 64'(dy_ff);
   assign dz = 64'(dz_ff);

   function automatic logic signed [63:0] sel_d(input logic [1:0] i,
                                                input logic signed [63:0] x,
                                                input logic signed [63:0] y,
                                                input logic signed [63:0] z);
      case (i)
         2'd0:    return x;
         2'd1:    return y;
         default: return z;
      endcase
   endfunction

   // virial component pairs in order xx yy zz xy xz yz
   assign vm   = pc_ff - PC_VIR;
   assign vidx = vm[3:1];
   always_comb begin
      case (vidx)
         3'd0:    begin ia = 2'd0; ib = 2'd0; end
         3'd1:    begin ia = 2'd1; ib = 2'd1; end
         3'd2:    begin ia = 2'd2; ib = 2'd2; end
         3'd3:    begin ia = 2'd0; ib = 2'd1; end
         3'd4:    begin ia = 2'd0; ib = 2'd2; end
         default: begin ia = 2'd1; ib = 2'd2; end
      endcase
   end

   // multiplier operands per step
   always_comb begin
      op_raw = 1'b0;
      case (pc_ff)
         PC_SQ_X:  begin op_a = dx; op_b = dx; op_raw = 1'b1; end
         PC_SQ_Y:  begin op_a = dy; op_b = dy; op_raw = 1'b1; end
         PC_SQ_Z:  begin op_a = dz; op_b = dz; op_raw = 1'b1; end
         PC_DR2:   begin op_a = dr_ff; op_b = dr_ff; end
         PC_C3K:   begin op_a = C_1P5; op_b = 64'(cfg.cubic_coeff); end
         PC_C3DR:  begin op_a = t_ff; op_b = dr_ff; end
         PC_C4K:   begin op_a = C_TWO; op_b = 64'(cfg.quartic_coeff); end
         PC_C4DR2: begin op_a = t_ff; op_b = dr2_ff; end
         PC_K2DR:  begin op_a = {31'd0, k2_ff, 1'b0}; op_b = dr_ff; end
         PC_DE:    begin op_a = t_ff; op_b = poly_ff; end
         PC_E3:    begin op_a = 64'(cfg.cubic_coeff); op_b = dr_ff; end
         PC_E4:    begin op_a = 64'(cfg.quartic_coeff); op_b = dr2_ff; end
         PC_EK2:   begin op_a = {32'd0, k2_ff}; op_b = dr2_ff; end
         PC_EB:    begin op_a = t_ff; op_b = pe_ff; end
         PC_FX:    begin op_a = dx; op_b = fb_ff; end
         PC_FY:    begin op_a = dy; op_b = fb_ff; end
         PC_FZ:    begin op_a = dz; op_b = fb_ff; end
         default: begin
            if (vm[0]) begin
               op_a = t_ff;
               op_b = fb_ff;
            end else begin
               op_a = sel_d(ia, dx, dy, dz);
               op_b = sel_d(ib, dx, dy, dz);
            end
         end
      endcase
   end

   // tally update, whole or one half per local end, split over the first and second accumulate step
   assign add0 = cfg.newton_mode || (ends_ff != 2'd0);
   assign add1 = !cfg.newton_mode && (ends_ff == 2'd2);
   assign ebx  = 64'(eb_ff);
   always_comb begin
      if (!acc_step_ff) begin
         esum_in = sop_ff ? '0 : esum_ff;
         if (cfg.energy_enable && add0)
            esum_in = sat_add64(esum_in, cfg.newton_mode ? ebx : half64(ebx));
         for (int m = 0; m < 6; m++) begin
            vsum_in[m] = sop_ff ? '0 : vsum_ff[m];
            if (cfg.virial_enable && add0)
               vsum_in[m] = sat_add64(vsum_in[m],
                                      cfg.newton_mode ? vir_ff[m] : half64(vir_ff[m]));
         end
      end else begin
         esum_in = esum_ff;
         if (cfg.energy_enable && add1) esum_in = sat_add64(esum_ff, half64(ebx));
         for (int m = 0; m < 6; m++) begin
            vsum_in[m] = vsum_ff[m];
            if (cfg.virial_enable && add1)
               vsum_in[m] = sat_add64(vsum_ff[m], half64(vir_ff[m]));
         end
      end
   end

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign out_free = !out_valid_ff || rsp_ch.ready;

   // control sequence and tallies
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= PC_SQ_X;
         acc_step_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         esum_ff      <= '0;
         for (int m = 0; m < 6; m++) vsum_ff[m] <= '0;
      end else begin
         // result slot empties unless a new result is loaded
         if (out_valid_ff && rsp_ch.ready && state_ff != ST_OUT) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  pc_ff    <= PC_SQ_X;
                  state_ff <= ST_MUL_GO;
               end
            end
            ST_MUL_GO: state_ff <= ST_MUL_WAIT;
            ST_MUL_WAIT: begin
               if (mul_done) begin
                  if (pc_ff == PC_SQ_Z) begin
                     state_ff <= ST_ROOT_GO;
                  end else if (pc_ff == PC_DE) begin
                     if (r_ff == '0) begin
                        pc_ff    <= PC_E3;
                        state_ff <= ST_MUL_GO;
                     end else begin
                        state_ff <= ST_DIV_GO;
                     end
                  end else if (pc_ff == PC_LAST) begin
                     acc_step_ff <= 1'b0;
                     state_ff    <= ST_ACC;
                  end else begin
                     pc_ff    <= pc_ff + 5'd1;
                     state_ff <= ST_MUL_GO;
                  end
               end
            end
            ST_ROOT_GO: state_ff <= ST_ROOT_WAIT;
            ST_ROOT_WAIT: begin
               if (root_done) begin
                  pc_ff    <= PC_DR2;
                  state_ff <= ST_MUL_GO;
               end
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  pc_ff    <= PC_E3;
                  state_ff <= ST_MUL_GO;
               end
            end
            ST_ACC: begin
               esum_ff <= esum_in;
               for (int m = 0; m < 6; m++) vsum_ff[m] <= vsum_in[m];
               acc_step_ff <= 1'b1;
               if (acc_step_ff) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // working values
   always_ff @(posedge clock) begin
      if (q_pop) begin
         dx_ff   <= q_item.delta_x;
         dy_ff   <= q_item.delta_y;
         dz_ff   <= q_item.delta_z;
         r0_ff   <= q_item.rest_length;
         k2_ff   <= q_item.stiffness;
         sop_ff  <= q_item.start_of_pass;
         ends_ff <= q_item.local_ends;
         rsq_ff  <= '0;
      end
      if (state_ff == ST_ROOT_WAIT && root_done) begin
         r_ff  <= root_res;
         dr_ff <= 64'({31'd0, root_res}) - 64'({32'd0, r0_ff});
      end
      // zero length leaves no force
      if (state_ff == ST_MUL_WAIT && mul_done && pc_ff == PC_DE && r_ff == '0)
         fb_ff <= '0;
      if (state_ff == ST_DIV_WAIT && div_done)
         fb_ff <= (div_res == S64_MIN) ? S64_MAX : -div_res;
      if (state_ff == ST_MUL_WAIT && mul_done) begin
         case (pc_ff)
            PC_SQ_X, PC_SQ_Y, PC_SQ_Z: rsq_ff <= rsq_ff + 64'(mul_res);
            PC_DR2:   dr2_ff  <= mul_res;
            PC_C3K:   t_ff    <= mul_res;
            PC_C3DR:  poly_ff <= sat_add64(C_ONE, mul_res);
            PC_C4K:   t_ff    <= mul_res;
            PC_C4DR2: poly_ff <= sat_add64(poly_ff, mul_res);
            PC_K2DR:  t_ff    <= mul_res;
            PC_DE:    de_ff   <= mul_res;
            PC_E3:    pe_ff   <= sat_add64(C_ONE, mul_res);
            PC_E4:    pe_ff   <= sat_add64(pe_ff, mul_res);
            PC_EK2:   t_ff    <= mul_res;
            PC_EB:    eb_ff   <= cfg.energy_enable ? sat32(mul_res) : '0;
            PC_FX:    fc_ff[0] <= sat32(mul_res);
            PC_FY:    fc_ff[1] <= sat32(mul_res);
            PC_FZ:    fc_ff[2] <= sat32(mul_res);
            default: begin
               if (vm[0]) vir_ff[vidx] <= mul_res;
               else t_ff <= mul_res;
            end
         endcase
      end
      // result register
      if (state_ff == ST_OUT && out_free) begin
         out_ff.force_x      <= fc_ff[0];
         out_ff.force_y      <= fc_ff[1];
         out_ff.force_z      <= fc_ff[2];
         out_ff.bond_energy  <= eb_ff;
         out_ff.energy_total <= esum_ff;
         out_ff.virial_xx    <= vsum_ff[0];
         out_ff.virial_yy    <= vsum_ff[1];
         out_ff.virial_zz    <= vsum_ff[2];
         out_ff.virial_xy    <= vsum_ff[3];
         out_ff.virial_xz    <= vsum_ff[4];
         out_ff.virial_yz    <= vsum_ff[5];
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.force_x      = out_ff.force_x;
   assign rsp_ch.force_y      = out_ff.force_y;
   assign rsp_ch.force_z      = out_ff.force_z;
   assign rsp_ch.bond_energy  = out_ff.bond_energy;
   assign rsp_ch.energy_total = out_ff.energy_total;
   assign rsp_ch.virial_xx    = out_ff.virial_xx;
   assign rsp_ch.virial_yy    = out_ff.virial_yy;
   assign rsp_ch.virial_zz    = out_ff.virial_zz;
   assign rsp_ch.virial_xy    = out_ff.virial_xy;
   assign rsp_ch.virial_xz    = out_ff.virial_xz;
   assign rsp_ch.virial_yz    = out_ff.virial_yz;

endmodule

// ===== sv/mm3_bond_force_tally_core.sv =====
`timescale 1ns / 1ps
// sequence: each bond runs 29 multiply steps on the one shared 32x32 multiplier (four
// partial products each), the two-bit-per-cycle square root and, for a nonzero length,
// the bit-serial divide
// overlap: the back end works one bond at a time; a two-entry queue takes new items meanwhile
// reset: sums cleared, registers back to defaults, queue and result slot empty
// ----------------------------------------------------------------------------
// mm3_bond_force_tally_core
// Bond stretch force, energy and virial tally with register bank, input
// queue and sequenced arithmetic back end.
// ----------------------------------------------------------------------------
module mm3_bond_force_tally_core
   import mm3bft_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   mm3bft_req_if.sink    req_ch,
   mm3bft_rsp_if.source  rsp_ch,
   mm3bft_csr_if.sink    csr_ch
);

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;

   assign csr_ch.ready = 1'b1;

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cubic_coeff   <= CUBIC_RESET;
         cfg_ff.quartic_coeff <= QUARTIC_RESET;
         cfg_ff.newton_mode   <= 1'b1;
         cfg_ff.energy_enable <= 1'b1;
         cfg_ff.virial_enable <= 1'b1;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_CUBIC:   cfg_ff.cubic_coeff   <= csr_ch.data;
            CSR_QUARTIC: cfg_ff.quartic_coeff <= csr_ch.data;
            CSR_NEWTON:  cfg_ff.newton_mode   <= csr_ch.data[0];
            CSR_ENERGY:  cfg_ff.energy_enable <= csr_ch.data[0];
            CSR_VIRIAL:  cfg_ff.virial_enable <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   mm3bft_front u_front (
      .clock (clock), .reset (reset), .req_ch (req_ch),
      .q_valid (q_valid), .q_item (q_item), .q_pop (q_pop)
   );

   mm3bft_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock (clock), .reset (reset), .cfg (cfg_ff),
      .q_valid (q_valid), .q_item (q_item), .q_pop (q_pop), .rsp_ch (rsp_ch)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bond stretch force and tally core. Bonds are fed through the
// request channel and each result is compared field by field against an
// in-bench bit-true predictor of forces, bond energy and the running sums.
// Runs several register settings, directed extremes, then random bonds.
// ----------------------------------------------------------------------------
module testbench;
   import mm3bft_pkg::*;

   localparam int FB = 16;
   localparam int LATENCY = 400;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      logic signed [31:0] dx, dy, dz;
      logic [31:0]        r0, k2;
      logic               loc1, loc2, sop;
   } bond_type;

   logic clock;
   logic reset;

   mm3bft_req_if req_ch ();
   mm3bft_rsp_if rsp_ch ();
   mm3bft_csr_if csr_ch ();

   mm3_bond_force_tally_core #(.FRACTION_BITS(FB)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // predictor state and register copy
   logic signed [63:0] k3_coeff, k4_coeff;
   logic               newton_on, energy_on, virial_on;
   logic signed [63:0] energy_acc;
   logic signed [63:0] virial_acc [6];

   bond_type   bond_queue[$];
   result_type expected_results[$];
   int         error_count;
   int         idle_cycles;
   bit         no_idling;
   int         hold_off;

   // saturate a magnitude with a sign
   function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input bit neg);
      if (neg) return (m >= 64'h8000_0000_0000_0000) ? S64_MIN : -$signed(m);
      return (m > 64'(S64_MAX)) ? S64_MAX : $signed(m);
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   // q multiply, truncated toward zero, saturated
   function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic [127:0] p;
      logic [127:0] s;
      bit neg;
      neg = a[63] != b[63];
      p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      s = p >> FB;
      if (s[127:64] != 0) return neg ? S64_MIN : S64_MAX;
      return apply_sign(s[63:0], neg);
   endfunction

   // (n << F) / d, truncated, saturated
   function automatic logic signed [63:0] q_div(input logic signed [63:0] n,
                                                input logic [63:0] d);
      logic [63:0] un, q, rm;
      bit neg;
      neg = n[63];
      un = abs64(n);
      q = un / d;
      rm = un % d;
      if (q >= (64'd1 << (63 - FB))) return neg ? S64_MIN : S64_MAX;
      return apply_sign((q << FB) + (rm << FB) / d, neg);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] halved(input logic signed [63:0] a);
      return a / 64'sd2;
   endfunction

   // predicted result of one bond, updates the running sums
   task automatic predict_bond(input bond_type b);
      logic signed [63:0] d [3];
      logic signed [63:0] vir [6];
      logic signed [63:0] one, dr, dr2, poly, de, fb, eb, pe;
      logic [63:0] rsq, r;
      int ends;
      int va [6];
      int vb [6];
      result_type res;
      va = '{0, 1, 2, 0, 0, 1};
      vb = '{0, 1, 2, 1, 2, 2};
      one = 64'sd1 <<< FB;
      d[0] = b.dx;
      d[1] = b.dy;
      d[2] = b.dz;
      rsq = 0;
      for (int a = 0; a < 3; a++) rsq = rsq + abs64(d[a]) * abs64(d[a]);
      r = int_sqrt(rsq);
      dr = $signed(r) - $signed({32'd0, b.r0});
      dr2 = q_mul(dr, dr);
      poly = sat_add64(one, q_mul(q_mul(64'sd3 <<< (FB - 1), k3_coeff), dr));
      poly = sat_add64(poly, q_mul(q_mul(64'sd2 <<< FB, k4_coeff), dr2));
      de = q_mul(q_mul($signed({31'd0, b.k2, 1'b0}), dr), poly);
      fb = 0;
      if (r > 0) fb = q_div(de, r);
      fb = (fb == S64_MIN) ? S64_MAX : -fb;
      eb = 0;
      if (energy_on) begin
         pe = sat_add64(sat_add64(one, q_mul(k3_coeff, dr)), q_mul(k4_coeff, dr2));
         eb = sat32(q_mul(q_mul($signed({32'd0, b.k2}), dr2), pe));
      end
      for (int m = 0; m < 6; m++) vir[m] = q_mul(q_mul(d[va[m]], d[vb[m]]), fb);
      if (b.sop) begin
         energy_acc = 0;
         for (int m = 0; m < 6; m++) virial_acc[m] = 0;
      end
      ends = int'(b.loc1) + int'(b.loc2);
      if (energy_on) begin
         if (newton_on) energy_acc = sat_add64(energy_acc, eb);
         else for (int a = 0; a < ends; a++) energy_acc = sat_add64(energy_acc, halved(eb));
      end
      if (virial_on) begin
         for (int m = 0; m < 6; m++) begin
            if (newton_on) virial_acc[m] = sat_add64(virial_acc[m], vir[m]);
            else for (int a = 0; a < ends; a++)
               virial_acc[m] = sat_add64(virial_acc[m], halved(vir[m]));
         end
      end
      res.force_x = sat32(q_mul(d[0], fb));
      res.force_y = sat32(q_mul(d[1], fb));
      res.force_z = sat32(q_mul(d[2], fb));
      res.bond_energy = eb[31:0];
      res.energy_total = energy_acc;
      res.virial_xx = virial_acc[0];
      res.virial_yy = virial_acc[1];
      res.virial_zz = virial_acc[2];
      res.virial_xy = virial_acc[3];
      res.virial_xz = virial_acc[4];
      res.virial_yz = virial_acc[5];
      expected_results.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // driver: one bond per accepted item, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         idle_cycles <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            req_ch.valid <= 1'b0;
         end else if (bond_queue.size() > 0) begin
            bond_type b;
            b = bond_queue.pop_front();
            predict_bond(b);
            req_ch.valid <= 1'b1;
            req_ch.delta_x <= b.dx;
            req_ch.delta_y <= b.dy;
            req_ch.delta_z <= b.dz;
            req_ch.rest_length <= b.r0;
            req_ch.stiffness <= b.k2;
            req_ch.first_local <= b.loc1;
            req_ch.second_local <= b.loc2;
            req_ch.start_of_pass <= b.sop;
            if (!no_idling && $urandom_range(0, 5) == 0) idle_cycles <= $urandom_range(1, 3);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: compares each result with the oldest prediction, random stalls
   int stall_cycles;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result item", 64'd0, 64'd0);
            end else begin
               result_type e;
               e = expected_results.pop_front();
               if (rsp_ch.force_x !== e.force_x)
                  report_mismatch("force_x", 64'(rsp_ch.force_x), 64'(e.force_x));
               if (rsp_ch.force_y !== e.force_y)
                  report_mismatch("force_y", 64'(rsp_ch.force_y), 64'(e.force_y));
               if (rsp_ch.force_z !== e.force_z)
                  report_mismatch("force_z", 64'(rsp_ch.force_z), 64'(e.force_z));
               if (rsp_ch.bond_energy !== e.bond_energy)
                  report_mismatch("bond_energy", 64'(rsp_ch.bond_energy),
                                  64'(e.bond_energy));
               if (rsp_ch.energy_total !== e.energy_total)
                  report_mismatch("energy_total", rsp_ch.energy_total, e.energy_total);
               if (rsp_ch.virial_xx !== e.virial_xx)
                  report_mismatch("virial_xx", rsp_ch.virial_xx, e.virial_xx);
               if (rsp_ch.virial_yy !== e.virial_yy)
                  report_mismatch("virial_yy", rsp_ch.virial_yy, e.virial_yy);
               if (rsp_ch.virial_zz !== e.virial_zz)
                  report_mismatch("virial_zz", rsp_ch.virial_zz, e.virial_zz);
               if (rsp_ch.virial_xy !== e.virial_xy)
                  report_mismatch("virial_xy", rsp_ch.virial_xy, e.virial_xy);
               if (rsp_ch.virial_xz !== e.virial_xz)
                  report_mismatch("virial_xz", rsp_ch.virial_xz, e.virial_xz);
               if (rsp_ch.virial_yz !== e.virial_yz)
                  report_mismatch("virial_yz", rsp_ch.virial_yz, e.virial_yz);
            end
         end
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!no_idling && $urandom_range(0, 5) == 0) begin
            stall_cycles <= $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
   end

   // watchdog on cycles with no accepted item
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("** mm3_bond_force_tally_core: FAILED **");
            $finish;
         end
      end
   end

   // register write while idle, predictor copy updated on accept
   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      csr_ch.index <= idx;
      csr_ch.data <= value;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_CUBIC:   k3_coeff = $signed(value);
         CSR_QUARTIC: k4_coeff = $signed(value);
         CSR_NEWTON:  newton_on = value[0];
         CSR_ENERGY:  energy_on = value[0];
         CSR_VIRIAL:  virial_on = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      while (bond_queue.size() > 0 || expected_results.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word(input int style);
      case (style)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
         2: return 32'(int'($urandom_range(0, 2 << FB)));
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   task automatic add_bond(input logic [31:0] x, y, z, r0, k2, input bit l1, l2, sp);
      bond_type b;
      b.dx = x; b.dy = y; b.dz = z; b.r0 = r0; b.k2 = k2;
      b.loc1 = l1; b.loc2 = l2; b.sop = sp;
      bond_queue.push_back(b);
   endtask

   task automatic add_random_bonds(input int count);
      int style;
      for (int i = 0; i < count; i++) begin
         style = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 3);
         add_bond(rand_word(style), rand_word(style), rand_word(style),
                  ($urandom_range(0, 3) == 0) ? $urandom() : rand_word(2),
                  ($urandom_range(0, 3) == 0) ? $urandom() : rand_word(2),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      logic [31:0] k3_set [4];
      logic [31:0] k4_set [4];
      error_count = 0;
      hold_off = 0;
      no_idling = 0;
      k3_coeff = CUBIC_RESET;
      k4_coeff = QUARTIC_RESET;
      newton_on = 1; energy_on = 1; virial_on = 1;
      energy_acc = 0;
      for (int m = 0; m < 6; m++) virial_acc[m] = 0;
      req_ch.valid = 0;
      req_ch.delta_x = 0; req_ch.delta_y = 0; req_ch.delta_z = 0;
      req_ch.rest_length = 0; req_ch.stiffness = 0;
      req_ch.first_local = 0; req_ch.second_local = 0; req_ch.start_of_pass = 0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0; csr_ch.index = 0; csr_ch.data = 0;
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed bonds at reset settings: zero length, extremes, locality
      add_bond(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1, 1, 1);
      add_bond(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
      add_bond(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0010_0000, 1, 0, 0);
      add_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 1, 0);
      add_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               0, 1, 0);
      add_bond(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0002_0000, 32'h0005_0000,
               1, 1, 0);
      add_bond(32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0001_0000, 32'h0020_0000,
               0, 0, 0);
      add_bond(32'h0003_0000, 32'h0004_0000, 0, 32'h0005_0000, 32'h0001_0000, 1, 1, 1);
      drain();

      // split mode, all locality combinations
      write_reg(CSR_NEWTON, 0);
      add_bond(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0003_0000, 0, 0, 1);
      add_bond(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0003_0000, 1, 0, 0);
      add_bond(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0003_0000, 0, 1, 0);
      add_bond(32'hFFFF_0001, 32'h0001_0000, 32'h7FFF_FFFF, 0, 32'h0003_0001, 1, 1, 0);
      drain();

      // energy and virial disabled, extreme coefficients
      write_reg(CSR_ENERGY, 0);
      write_reg(CSR_VIRIAL, 0);
      write_reg(CSR_CUBIC, 32'h7FFF_FFFF);
      write_reg(CSR_QUARTIC, 32'h8000_0000);
      add_bond(32'h0002_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0010_0000, 1, 1, 0);
      add_bond(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1, 1, 1);
      drain();
      write_reg(CSR_ENERGY, 1);
      write_reg(CSR_VIRIAL, 1);

      // back pressure: receiver holds off while the sender keeps offering
      hold_off = 3000;
      add_random_bonds(10);
      drain();

      // random phases over several settings
      k3_set = '{32'hFFFD_731B, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
      k4_set = '{32'h0003_CB0A, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_CUBIC, ($urandom_range(0, 3) == 0) ? $urandom() : k3_set[ph % 4]);
         write_reg(CSR_QUARTIC, ($urandom_range(0, 3) == 0) ? $urandom() : k4_set[ph % 4]);
         write_reg(CSR_NEWTON, 32'(ph % 2));
         write_reg(CSR_ENERGY, 32'((ph % 3) != 2));
         write_reg(CSR_VIRIAL, 32'((ph % 4) != 3));
         if (ph == 7) no_idling = 1;
         add_random_bonds(250);
         drain();
      end

      if (error_count == 0) begin
         $display("** mm3_bond_force_tally_core: PASSED **");
      end else begin
         $display("** mm3_bond_force_tally_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/mm3bft_pkg.sv
sv/mm3bft_ifs.sv
sv/mm3bft_front.sv
sv/mm3bft_mul.sv
sv/mm3bft_root.sv
sv/mm3bft_div.sv
sv/mm3bft_back.sv
sv/mm3_bond_force_tally_core.sv
tb/testbench.sv
